FILE: hw/rtl/srs3_pkg.sv
// Shared types, constants and helpers of the S3 record encoder.
`default_nettype none
package srs3_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned QUEUE_DEPTH = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD_BYTES = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT    = 17'd126972;
    localparam logic [BYTE_W-1:0]  RECORD_DEFAULT = 8'd239;
    localparam logic [BYTE_W-1:0]  RECORD_LIMIT   = 8'd250;
    localparam logic [BYTE_W-1:0]  COUNT_EXTRA    = 8'd5;

    localparam logic [BYTE_W-1:0] CH_S      = 8'h53;
    localparam logic [BYTE_W-1:0] CH_3      = 8'h33;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LETTER = 8'd7;

    // character positions inside one record's text
    localparam logic [POS_W-1:0] POS_S        = 5'd0;
    localparam logic [POS_W-1:0] POS_3        = 5'd1;
    localparam logic [POS_W-1:0] POS_FIRST_HEX = 5'd2;
    localparam logic [POS_W-1:0] POS_DATA_HI  = 5'd12;
    localparam logic [POS_W-1:0] POS_DATA_LO  = 5'd13;
    localparam logic [POS_W-1:0] POS_CHK_LO   = 5'd15;
    localparam logic [POS_W-1:0] POS_NL       = 5'd16;

    // one data byte, classified, with everything needed to print it
    typedef struct packed {
        logic              open;   // print the record header first
        logic [BYTE_W-1:0] cnt;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              close;  // print checksum and newline after
        logic [BYTE_W-1:0] chk;
        logic              eos;
    } t_cmd;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] c;
        c = {4'h0, nib} + CH_ZERO;
        if (c > CH_NINE) begin
            c = c + CH_LETTER;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/srs3_front.sv
// Front end: configuration registers, session bookkeeping and byte classification.
`default_nettype none
module srs3_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [srs3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [srs3_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [srs3_pkg::BYTE_W-1:0]         i_data_byte,
    input  wire logic                                i_q_full,
    output logic                                     o_push,
    output srs3_pkg::t_cmd                           o_cmd
);

    logic [srs3_pkg::ADDR_W-1:0]  r_cfg_start;
    logic [srs3_pkg::COUNT_W-1:0] r_cfg_total;
    logic [srs3_pkg::BYTE_W-1:0]  r_cfg_max;
    logic [srs3_pkg::COUNT_W-1:0] r_rem,  n_rem;
    logic [srs3_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [srs3_pkg::BYTE_W-1:0]  r_left, n_left;
    logic [srs3_pkg::BYTE_W-1:0]  r_sum,  n_sum;

    logic                         accept;
    logic                         open;
    logic                         active;
    logic [srs3_pkg::BYTE_W-1:0]  lim;
    logic [srs3_pkg::BYTE_W-1:0]  rec_len;
    logic [srs3_pkg::BYTE_W-1:0]  cnt;
    logic [srs3_pkg::BYTE_W-1:0]  left_now;
    logic [srs3_pkg::BYTE_W-1:0]  sum_base;
    logic [srs3_pkg::BYTE_W-1:0]  sum_new;
    logic [srs3_pkg::COUNT_W-1:0] total_clamped;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign total_clamped =
        (i_cfg_wdata[srs3_pkg::COUNT_W-1:0] > srs3_pkg::COUNT_LIMIT) ?
        srs3_pkg::COUNT_LIMIT : i_cfg_wdata[srs3_pkg::COUNT_W-1:0];

    always_comb begin
        open   = (r_left == '0);
        active = !(open && (r_rem == '0));
        priority if (r_cfg_max == '0) begin
            lim = 8'd1;
        end else if (r_cfg_max > srs3_pkg::RECORD_LIMIT) begin
            lim = srs3_pkg::RECORD_LIMIT;
        end else begin
            lim = r_cfg_max;
        end
        rec_len  = (r_rem < {9'd0, lim}) ? r_rem[srs3_pkg::BYTE_W-1:0] : lim;
        cnt      = rec_len + srs3_pkg::COUNT_EXTRA;
        left_now = open ? rec_len : r_left;
        sum_base = open ? (cnt + r_addr[31:24] + r_addr[23:16] + r_addr[15:8] + r_addr[7:0])
                        : r_sum;
        sum_new  = sum_base + i_data_byte;

        o_cmd.open  = open;
        o_cmd.cnt   = cnt;
        o_cmd.addr  = r_addr;
        o_cmd.data  = i_data_byte;
        o_cmd.close = (left_now == 8'd1);
        o_cmd.chk   = ~sum_new;
        o_cmd.eos   = (left_now == 8'd1) && (r_rem == 17'd1);
        o_push      = accept && active;

        n_rem  = r_rem;
        n_addr = r_addr;
        n_left = r_left;
        n_sum  = r_sum;
        if (o_push) begin
            n_rem  = r_rem - 17'd1;
            n_addr = r_addr + 32'd1;
            n_left = left_now - 8'd1;
            n_sum  = o_cmd.close ? 8'd0 : sum_new;
            if (o_cmd.eos) begin
                n_rem  = r_cfg_total;
                n_addr = r_cfg_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= '0;
            r_cfg_total <= '0;
            r_cfg_max   <= srs3_pkg::RECORD_DEFAULT;
            r_rem       <= '0;
            r_addr      <= '0;
            r_left      <= '0;
            r_sum       <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index == srs3_pkg::REG_START_ADDRESS)) begin
            r_cfg_start <= i_cfg_wdata;
            r_rem       <= r_cfg_total;
            r_addr      <= i_cfg_wdata;
            r_left      <= '0;
            r_sum       <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index == srs3_pkg::REG_TOTAL_COUNT)) begin
            r_cfg_total <= total_clamped;
            r_rem       <= total_clamped;
            r_addr      <= r_cfg_start;
            r_left      <= '0;
            r_sum       <= '0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == srs3_pkg::REG_MAX_RECORD_BYTES)) begin
                r_cfg_max <= i_cfg_wdata[srs3_pkg::BYTE_W-1:0];
            end
            r_rem  <= n_rem;
            r_addr <= n_addr;
            r_left <= n_left;
            r_sum  <= n_sum;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/srs3_queue.sv
// Short command queue between front end and printer.
`default_nettype none
module srs3_queue #(
    parameter int unsigned DEPTH = srs3_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire srs3_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output srs3_pkg::t_cmd      o_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    srs3_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/srs3_back.sv
// Printer: walks one command's characters into the output register.
`default_nettype none
module srs3_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire srs3_pkg::t_cmd              i_cmd,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [srs3_pkg::BYTE_W-1:0]      o_out_char,
    output logic                             o_last_of_run,
    output logic                             o_end_of_record,
    output logic                             o_end_of_session
);

    logic                          r_mid;
    logic [srs3_pkg::POS_W-1:0]    r_pos;
    logic                          r_valid;
    logic [srs3_pkg::BYTE_W-1:0]   r_char;
    logic                          r_last;
    logic                          r_eor;
    logic                          r_eos;

    logic                          load;
    logic                          step;
    logic [srs3_pkg::POS_W-1:0]    pos;
    logic [srs3_pkg::POS_W-1:0]    pos_end;
    logic [3:0]                    nib_idx;
    logic [5:0]                    nib_shift;
    logic [55:0]                   nib_vec;
    logic [3:0]                    nib;
    logic [srs3_pkg::BYTE_W-1:0]   ch;

    assign load  = !r_valid || i_out_ready;
    assign step  = load && i_q_valid;

    always_comb begin
        pos       = r_mid ? r_pos : (i_cmd.open ? srs3_pkg::POS_S : srs3_pkg::POS_DATA_HI);
        pos_end   = i_cmd.close ? srs3_pkg::POS_NL : srs3_pkg::POS_DATA_LO;
        nib_vec   = {i_cmd.cnt, i_cmd.addr, i_cmd.data, i_cmd.chk};
        nib_idx   = 4'(pos - srs3_pkg::POS_FIRST_HEX);
        nib_shift = {4'd13 - nib_idx, 2'b00};
        nib       = nib_vec[nib_shift +: 4];
        priority if (pos == srs3_pkg::POS_S) begin
            ch = srs3_pkg::CH_S;
        end else if (pos == srs3_pkg::POS_3) begin
            ch = srs3_pkg::CH_3;
        end else if (pos == srs3_pkg::POS_NL) begin
            ch = srs3_pkg::CH_NL;
        end else begin
            ch = srs3_pkg::hex_digit(nib);
        end
    end

    assign o_pop = step && (pos == pos_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (step) begin
                r_mid <= (pos != pos_end);
                r_pos <= pos + srs3_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_char <= ch;
            r_last <= (pos == pos_end);
            r_eor  <= (pos == srs3_pkg::POS_NL);
            r_eos  <= (pos == srs3_pkg::POS_NL) && i_cmd.eos;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_out_char       = r_char;
    assign o_last_of_run    = r_last;
    assign o_end_of_record  = r_eor;
    assign o_end_of_session = r_eos;

endmodule
`default_nettype wire

FILE: hw/rtl/srecord_s3_encoder.sv
// Top level of the S3 record encoder: front end, command queue and printer.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_data_byte): one data byte per beat.
//   Output channel (o_out_valid / i_out_ready): one ASCII character per beat,
//   with o_last_of_run on the final character a byte causes, o_end_of_record
//   on each record's newline and o_end_of_session on the session's last one.
//   Configuration port: write start_address (0), total_count (1) or
//   max_record_bytes (2) only while the block is idle. Writing 0 or 1
//   restarts the session; total_count clamps at 126972.
//   A byte that arrives with no session bytes due is taken and dropped.
// Throughput
//   A byte passes through the queue and then the output register before its
//   first character leaves. The output register sends one character per
//   cycle while the receiver is ready; a byte prints 2 characters inside a
//   record, 14 when it opens a record and 3 more when it closes one. The
//   front end takes one byte per cycle while the queue has room.
// Reset and stall
//   Reset clears the queue and output register and loads register defaults.
//   When the receiver stalls, hold the character; the queue fills and then
//   o_in_ready drops until the printer drains an entry.
`default_nettype none
module srecord_s3_encoder #(
    parameter int unsigned QUEUE_DEPTH = srs3_pkg::QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [srs3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [srs3_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [srs3_pkg::BYTE_W-1:0]      i_data_byte,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [srs3_pkg::BYTE_W-1:0]           o_out_char,
    output logic                                  o_last_of_run,
    output logic                                  o_end_of_record,
    output logic                                  o_end_of_session
);

    // front end to queue
    logic           push;
    logic           q_full;
    srs3_pkg::t_cmd push_cmd;
    // queue to printer
    logic           pop;
    logic           q_valid;
    srs3_pkg::t_cmd head_cmd;

    srs3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    srs3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    srs3_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_cmd            (head_cmd),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_char       (o_out_char),
        .o_last_of_run    (o_last_of_run),
        .o_end_of_record  (o_end_of_record),
        .o_end_of_session (o_end_of_session)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/srs3_checker.sv
// Port-level checks of the S3 record encoder, bound to the top level.
`default_nettype none
module srs3_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [srs3_pkg::BYTE_W-1:0]  o_out_char,
    input wire logic                         o_last_of_run,
    input wire logic                         o_end_of_record,
    input wire logic                         o_end_of_session
);

    // hold a stalled character
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_char))
        else $error("stalled output character changed");

    // drop the output after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_record |->
            (o_out_char == srs3_pkg::CH_NL) && o_last_of_run)
        else $error("record end not on a closing newline");

    a_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_session |-> o_end_of_record)
        else $error("session end without record end");

endmodule

bind srecord_s3_encoder srs3_checker u_srs3_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_char       (o_out_char),
    .o_last_of_run    (o_last_of_run),
    .o_end_of_record  (o_end_of_record),
    .o_end_of_session (o_end_of_session)
);
`default_nettype wire
